### rtl/y2i_pkg.sv
// ----------------------------------------------------------------------------
// y2i_pkg
// Shared types and constants of the YUYV 4:2:2 to I420 converter.
// ----------------------------------------------------------------------------
package y2i_pkg;

   localparam int PIX_W      = 8;
   localparam int LUMA_W     = 20;
   localparam int CHROMA_W   = 18;
   localparam int CFG_W      = 11;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int STORE_W    = 2 * PIX_W;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;

   localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd720;
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd576;

   // Register index, taken from byte address bit 2
   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   // Item in flight through the line buffer read
   typedef struct packed {
      logic [LUMA_W-1:0]   luma_index;
      logic [PIX_W-1:0]    luma_first;
      logic [PIX_W-1:0]    luma_second;
      logic                chroma_valid;
      logic [CHROMA_W-1:0] chroma_index;
      logic [PIX_W-1:0]    cb;
      logic [PIX_W-1:0]    cr;
      logic                frame_end;
   } y2i_item_type;

   // Result held in the output register
   typedef struct packed {
      logic [LUMA_W-1:0]   luma_index;
      logic [PIX_W-1:0]    luma_first;
      logic [PIX_W-1:0]    luma_second;
      logic                chroma_valid;
      logic [CHROMA_W-1:0] chroma_index;
      logic [PIX_W-1:0]    cb_average;
      logic [PIX_W-1:0]    cr_average;
      logic                frame_end;
   } y2i_result_type;

   // Line buffer access issued by the front end
   typedef struct packed {
      logic               we;
      logic               re;
      logic [STORE_W-1:0] wdata;
   } y2i_ram_ctl_type;

endpackage

### rtl/y2i_ram.sv
// ----------------------------------------------------------------------------
// y2i_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module y2i_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      // hold read data while no read is issued
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/y2i_front.sv
// ----------------------------------------------------------------------------
// y2i_front
// Raster counters, line buffer access and the read-wait stage register.
// ----------------------------------------------------------------------------
module y2i_front #(
   parameter int MAX_WIDTH  = y2i_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = y2i_pkg::MAX_HEIGHT_DEF,
   parameter int DEPTH      = MAX_WIDTH / 2,
   parameter int COL_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [y2i_pkg::CFG_W-1:0]     frame_width,
   input  logic [y2i_pkg::CFG_W-1:0]     frame_height,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [y2i_pkg::PIX_W-1:0]     req_in_luma_first,
   input  logic [y2i_pkg::PIX_W-1:0]     req_in_cb,
   input  logic [y2i_pkg::PIX_W-1:0]     req_in_luma_second,
   input  logic [y2i_pkg::PIX_W-1:0]     req_in_cr,
   output y2i_pkg::y2i_ram_ctl_type      ram_ctl,
   output logic [COL_W-1:0]              ram_addr,
   output logic                          s1_valid,
   output y2i_pkg::y2i_item_type         s1_item,
   input  logic                          s1_ready
);

   localparam int ROW_W     = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
   localparam int CW        = (COL_W + 1 > y2i_pkg::CFG_W) ? COL_W + 1 : y2i_pkg::CFG_W;
   localparam int RW        = (ROW_W + 1 > y2i_pkg::CFG_W) ? ROW_W + 1 : y2i_pkg::CFG_W;
   localparam int MAXH_EVEN = ((MAX_HEIGHT / 2) * 2 < 2) ? 2 : (MAX_HEIGHT / 2) * 2;

   logic [COL_W-1:0]             col_ff, col_in;
   logic [ROW_W-1:0]             row_ff, row_in;
   logic [y2i_pkg::LUMA_W-1:0]   luma_ff, luma_in;
   logic [y2i_pkg::CHROMA_W-1:0] chroma_ff, chroma_in;
   logic                         s1_valid_ff, s1_valid_in;
   y2i_pkg::y2i_item_type        s1_ff, s1_in;

   logic [CW-1:0] w_half, cols, col_sat;
   logic [RW-1:0] h_even, rows;
   logic          accept, odd_row, last_col, last_row;

   assign req_ready = !s1_valid_ff || s1_ready;
   assign accept    = req_valid && req_ready;
   assign odd_row   = row_ff[0];

   always_comb begin
      // macropixels per line, clamped to the line buffer
      w_half = CW'(frame_width[y2i_pkg::CFG_W-1:1]);
      if (w_half == '0) begin
         cols = CW'(1);
      end else if (w_half > CW'(DEPTH)) begin
         cols = CW'(DEPTH);
      end else begin
         cols = w_half;
      end
      // a column beyond a lowered limit counts as the last one
      col_sat  = (CW'(col_ff) >= cols) ? cols - CW'(1) : CW'(col_ff);
      last_col = (CW'(col_ff) + CW'(1) >= cols);

      h_even = RW'({frame_height[y2i_pkg::CFG_W-1:1], 1'b0});
      if (h_even < RW'(2)) begin
         rows = RW'(2);
      end else if (h_even > RW'(MAXH_EVEN)) begin
         rows = RW'(MAXH_EVEN);
      end else begin
         rows = h_even;
      end
      last_row = (RW'(row_ff) + RW'(1) >= rows);

      ram_addr      = col_sat[COL_W-1:0];
      ram_ctl.we    = accept && !odd_row;
      ram_ctl.re    = accept && odd_row;
      ram_ctl.wdata = {req_in_cr, req_in_cb};

      // advance the raster position
      col_in    = col_ff;
      row_in    = row_ff;
      luma_in   = luma_ff;
      chroma_in = chroma_ff;
      if (accept) begin
         luma_in   = luma_ff + y2i_pkg::LUMA_W'(2);
         chroma_in = odd_row ? chroma_ff + y2i_pkg::CHROMA_W'(1) : chroma_ff;
         if (last_col) begin
            col_in = '0;
            if (last_row) begin
               row_in    = '0;
               luma_in   = '0;
               chroma_in = '0;
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end else begin
            col_in = col_sat[COL_W-1:0] + COL_W'(1);
         end
      end

      s1_in.luma_index   = luma_ff;
      s1_in.luma_first   = req_in_luma_first;
      s1_in.luma_second  = req_in_luma_second;
      s1_in.chroma_valid = odd_row;
      s1_in.chroma_index = odd_row ? chroma_ff : '0;
      s1_in.cb           = req_in_cb;
      s1_in.cr           = req_in_cr;
      s1_in.frame_end    = last_col && last_row;

      s1_valid_in = accept || (s1_valid_ff && !s1_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         luma_ff     <= '0;
         chroma_ff   <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         luma_ff     <= luma_in;
         chroma_ff   <= chroma_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1_item  = s1_ff;

endmodule

### rtl/y2i_back.sv
// ----------------------------------------------------------------------------
// y2i_back
// Chroma averaging against the stored row and the output register.
// ----------------------------------------------------------------------------
module y2i_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              s1_valid,
   input  y2i_pkg::y2i_item_type             s1_item,
   output logic                              s1_ready,
   input  logic [y2i_pkg::STORE_W-1:0]       ram_rdata,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output y2i_pkg::y2i_result_type           rsp_item
);

   logic                    out_valid_ff, out_valid_in;
   y2i_pkg::y2i_result_type out_ff, out_in;
   logic [y2i_pkg::PIX_W:0] cb_sum, cr_sum;
   logic                    load;

   assign s1_ready = !out_valid_ff || rsp_ready;
   assign load     = s1_valid && s1_ready;

   always_comb begin
      cb_sum = {1'b0, ram_rdata[y2i_pkg::PIX_W-1:0]} + {1'b0, s1_item.cb};
      cr_sum = {1'b0, ram_rdata[y2i_pkg::STORE_W-1:y2i_pkg::PIX_W]} + {1'b0, s1_item.cr};

      out_in.luma_index   = s1_item.luma_index;
      out_in.luma_first   = s1_item.luma_first;
      out_in.luma_second  = s1_item.luma_second;
      out_in.chroma_valid = s1_item.chroma_valid;
      out_in.chroma_index = s1_item.chroma_index;
      out_in.cb_average   = s1_item.chroma_valid ? cb_sum[y2i_pkg::PIX_W:1] : '0;
      out_in.cr_average   = s1_item.chroma_valid ? cr_sum[y2i_pkg::PIX_W:1] : '0;
      out_in.frame_end    = s1_item.frame_end;

      out_valid_in = load || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_ff;

endmodule

### rtl/yuyv422_to_i420_converter_unit.sv
// ----------------------------------------------------------------------------
// yuyv422_to_i420_converter_unit
// Packed YUYV 4:2:2 macropixels in, planar I420 luma and chroma writes out.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* carries one macropixel per transfer in raster order; rsp_* carries
//    one result per macropixel: both luma bytes with the luma-plane index and,
//    on odd rows, the Cb/Cr average of the two rows with its chroma index.
//  - Even rows store their chroma pair in a line buffer RAM (one entry per
//    macropixel column); odd rows read it back and average, floor((a+b)/2).
//  - A result passes the read-wait stage register, with the registered RAM
//    read, and then the output register.
//  - Throughput: one macropixel per cycle unless stalled; each item takes exactly
//    one RAM access, a write on even rows or a read on odd rows, at acceptance.
//  - Stall: when rsp_ready drops, the output register and the read-wait stage
//    hold; req_ready falls only when both are full.
//  - Reset clears counters, positions and pipeline valids and loads the
//    default frame size 720x576. The line buffer is not cleared; no pass runs.
//  - Program frame_width (0x0) and frame_height (0x4) only while idle.
// ----------------------------------------------------------------------------
module yuyv422_to_i420_converter_unit #(
   parameter int MAX_WIDTH  = y2i_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = y2i_pkg::MAX_HEIGHT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // macropixel input
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [y2i_pkg::PIX_W-1:0]           req_in_luma_first,
   input  logic [y2i_pkg::PIX_W-1:0]           req_in_cb,
   input  logic [y2i_pkg::PIX_W-1:0]           req_in_luma_second,
   input  logic [y2i_pkg::PIX_W-1:0]           req_in_cr,
   // planar result
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [y2i_pkg::LUMA_W-1:0]          rsp_luma_index,
   output logic [y2i_pkg::PIX_W-1:0]           rsp_out_luma_first,
   output logic [y2i_pkg::PIX_W-1:0]           rsp_out_luma_second,
   output logic                                rsp_chroma_valid,
   output logic [y2i_pkg::CHROMA_W-1:0]        rsp_chroma_index,
   output logic [y2i_pkg::PIX_W-1:0]           rsp_cb_average,
   output logic [y2i_pkg::PIX_W-1:0]           rsp_cr_average,
   output logic                                rsp_frame_end,
   // register port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [y2i_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [y2i_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [y2i_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);

   localparam int DEPTH = MAX_WIDTH / 2;
   localparam int COL_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [y2i_pkg::CFG_W-1:0]   frame_width_ff, frame_width_in;
   logic [y2i_pkg::CFG_W-1:0]   frame_height_ff, frame_height_in;
   logic                        csr_write;

   y2i_pkg::y2i_ram_ctl_type    ram_ctl;
   logic [COL_W-1:0]            ram_addr;
   logic [y2i_pkg::STORE_W-1:0] ram_rdata;
   logic                        s1_valid, s1_ready;
   y2i_pkg::y2i_item_type       s1_item;
   y2i_pkg::y2i_result_type     rsp_item;

   // Register port: zero wait states, write on the access phase
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      prdata          = '0;
      unique case (paddr[2])
         y2i_pkg::REG_FRAME_WIDTH: begin
            prdata = y2i_pkg::CSR_DATA_W'(frame_width_ff);
            if (csr_write) begin
               frame_width_in = pwdata[y2i_pkg::CFG_W-1:0];
            end
         end
         y2i_pkg::REG_FRAME_HEIGHT: begin
            prdata = y2i_pkg::CSR_DATA_W'(frame_height_ff);
            if (csr_write) begin
               frame_height_in = pwdata[y2i_pkg::CFG_W-1:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= y2i_pkg::FRAME_WIDTH_RST;
         frame_height_ff <= y2i_pkg::FRAME_HEIGHT_RST;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   // Counters and line buffer access
   y2i_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .DEPTH      (DEPTH),
      .COL_W      (COL_W)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .frame_width        (frame_width_ff),
      .frame_height       (frame_height_ff),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_in_luma_first  (req_in_luma_first),
      .req_in_cb          (req_in_cb),
      .req_in_luma_second (req_in_luma_second),
      .req_in_cr          (req_in_cr),
      .ram_ctl            (ram_ctl),
      .ram_addr           (ram_addr),
      .s1_valid           (s1_valid),
      .s1_item            (s1_item),
      .s1_ready           (s1_ready)
   );

   // Chroma line buffer: Cb in the low byte, Cr in the high byte.
   // Write and read never target the same entry in one cycle; a read issued
   // the cycle after a write sees the new data.
   y2i_ram #(
      .WIDTH (y2i_pkg::STORE_W),
      .DEPTH (DEPTH),
      .AW    (COL_W)
   ) u_line_ram (
      .clock (clock),
      .we    (ram_ctl.we),
      .waddr (ram_addr),
      .wdata (ram_ctl.wdata),
      .re    (ram_ctl.re),
      .raddr (ram_addr),
      .rdata (ram_rdata)
   );

   // Averaging and output register
   y2i_back u_back (
      .clock     (clock),
      .reset     (reset),
      .s1_valid  (s1_valid),
      .s1_item   (s1_item),
      .s1_ready  (s1_ready),
      .ram_rdata (ram_rdata),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   assign rsp_luma_index      = rsp_item.luma_index;
   assign rsp_out_luma_first  = rsp_item.luma_first;
   assign rsp_out_luma_second = rsp_item.luma_second;
   assign rsp_chroma_valid    = rsp_item.chroma_valid;
   assign rsp_chroma_index    = rsp_item.chroma_index;
   assign rsp_cb_average      = rsp_item.cb_average;
   assign rsp_cr_average      = rsp_item.cr_average;
   assign rsp_frame_end       = rsp_item.frame_end;

   // Input back-pressure only comes from a stalled, full output side
   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready && s1_valid))
      else $error("input stalled while output side can move");

   // A luma index always points at an even pixel
   a_luma_even: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_luma_index[0])
      else $error("odd luma index");

   // Even-row results carry no chroma
   a_chroma_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_chroma_valid) |->
      (rsp_chroma_index == '0 && rsp_cb_average == '0 && rsp_cr_average == '0))
      else $error("chroma fields set without chroma");

   // The read-wait stage holds its item, and an odd-row item its read data,
   // while the output side stalls
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid && !s1_ready) |=>
      (s1_valid && $stable(s1_item) && (!s1_item.chroma_valid || $stable(ram_rdata))))
      else $error("stalled stage lost its item");

endmodule
